[sv/pcas_pkg.sv]
// Package for the PCI configuration access splitter.
// Holds the request job type, sequencer states and the port and address constants.
// No dependencies.
package pcas_pkg;

  // Longest request in bytes; longer requests saturate to this
  localparam int unsigned MAX_LEN = 64;

  localparam logic [6:0]  LEN_MAX      = 7'(MAX_LEN);
  localparam logic [31:0] CONF_ENABLE  = 32'h8000_0000;
  localparam logic [15:0] PORT_ADDR1   = 16'h0CFC;
  localparam logic [15:0] PORT_BASE2   = 16'hC000;
  localparam logic [7:0]  ENABLE2      = 8'hF0;
  localparam logic [8:0]  REG_LIMIT    = 9'h100;
  localparam logic [4:0]  DEV_LIMIT2   = 5'd16;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Request modes
  localparam logic [1:0] MODE_M1_RD = 2'd0;
  localparam logic [1:0] MODE_M1_WR = 2'd1;
  localparam logic [1:0] MODE_M2_RD = 2'd2;
  localparam logic [1:0] MODE_M2_WR = 2'd3;

  // Classified request handed from front to back
  typedef struct packed {
    logic       wr;      // write access
    logic       mech2;   // configuration mechanism 2
    logic       bad;     // rejected on the first chunk
    logic       empty;   // zero length after saturation
    logic [6:0] len;     // saturated length
    logic [7:0] bus;
    logic [4:0] dev;
    logic [2:0] func;
    logic [7:0] off;     // start offset, low byte
  } job_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_t;

endpackage

[sv/pci_config_access_splitter_unit.sv]
// A request beat is written to the queue, then fetched into the job register, and
// each chunk is registered as a result beat. A request of k chunks holds the back
// end for one fetch from the queue, then one chunk per cycle while the result
// channel is not stalled. A zero-length request, or one rejected on its first
// chunk, gives one beat; a later rejection adds one error beat after the good chunks.
// Reset: synchronous, active low; empties the queue, idles the sequencer and
// drops any pending result beat.
//
// Top level of the PCI configuration access splitter.
// Depends on pcas_pkg, pcas_front and pcas_back.
module pci_config_access_splitter_unit
  import pcas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // bus_number[7:0], device_number[12:8],
                                  // function_number[15:13], start_offset[27:16],
                                  // byte_length[34:28], zero fill[39:35]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // address_word[31:0], bus_port_value[39:32],
                                  // data_port[55:40], chunk_bytes[58:56],
                                  // buffer_offset[65:59], zero fill[71:66]
  output logic [1:0]  out_tuser,  // is_write[0], error_flag[1]
  output logic        out_tlast   // last_chunk
);

  job_t        job;
  logic        job_valid;
  logic        job_pop;
  logic [31:0] addr;
  logic [7:0]  busv;
  logic [15:0] port;
  logic [2:0]  nbytes;
  logic [6:0]  done;
  logic        wr, err;

  // Front: accept, classify and queue each request beat
  pcas_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_bus    (in_tdata[7:0]),
    .in_dev    (in_tdata[12:8]),
    .in_func   (in_tdata[15:13]),
    .in_start  (in_tdata[27:16]),
    .in_len    (in_tdata[34:28]),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  // Back: split the head request into aligned chunks, one result beat each
  pcas_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_addr   (addr),
    .out_busv   (busv),
    .out_port   (port),
    .out_nbytes (nbytes),
    .out_done   (done),
    .out_wr     (wr),
    .out_err    (err),
    .out_last   (out_tlast)
  );

  // Pack the result beat, lowest field first
  assign out_tdata = {6'd0, done, nbytes, port, busv, addr};
  assign out_tuser = {err, wr};

endmodule

[sv/pcas_front.sv]
// Front end of the splitter: accepts requests, classifies them, queues them.
// Depends on pcas_pkg.
module pcas_front
  import pcas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_bus,
  input  logic [4:0]  in_dev,
  input  logic [2:0]  in_func,
  input  logic [11:0] in_start,
  input  logic [6:0]  in_len,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_pop
);

  job_t       q_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  job_t       cls;
  logic       push, pop;

  // Classify: saturate length, flag bad device or register
  always_comb begin
    cls.wr    = (in_mode == MODE_M1_WR) || (in_mode == MODE_M2_WR);
    cls.mech2 = (in_mode == MODE_M2_RD) || (in_mode == MODE_M2_WR);
    cls.len   = (in_len > LEN_MAX) ? LEN_MAX : in_len;
    cls.empty = (cls.len == 7'd0);
    cls.bad   = (in_start >= 12'(REG_LIMIT)) || (cls.mech2 && (in_dev >= DEV_LIMIT2));
    cls.bus   = in_bus;
    cls.dev   = in_dev;
    cls.func  = in_func;
    cls.off   = in_start[7:0];
  end

  assign in_tready = (count_r != 2'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign job_valid = (count_r != 2'd0);
  assign pop       = job_valid && job_pop;
  assign job       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[sv/pcas_back.sv]
// Back end of the splitter: walks one queued request, one chunk per beat.
// Depends on pcas_pkg.
module pcas_back
  import pcas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_addr,
  output logic [7:0]  out_busv,
  output logic [15:0] out_port,
  output logic [2:0]  out_nbytes,
  output logic [6:0]  out_done,
  output logic        out_wr,
  output logic        out_err,
  output logic        out_last
);

  seq_state_t  state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [8:0]  off_r, off_nxt;
  logic [6:0]  done_r, done_nxt;
  logic        valid_r, valid_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  busv_r, busv_nxt;
  logic [15:0] port_r, port_nxt;
  logic [2:0]  nbytes_r, nbytes_nxt;
  logic [6:0]  bdone_r, bdone_nxt;
  logic        wr_r, wr_nxt;
  logic        err_r, err_nxt;
  logic        last_r, last_nxt;

  logic [6:0]  left;
  logic [1:0]  lo;
  logic [2:0]  n;
  logic        err, fin, slot_free, load;

  // Chunk size: alignment of the offset, cut down to the bytes left
  always_comb begin
    left = job_r.len - done_r;
    lo   = off_r[1:0];
    case (lo)
      2'd0:    n = (left >= 7'd4) ? 3'd4 : ((left >= 7'd2) ? 3'd2 : 3'd1);
      2'd2:    n = (left >= 7'd2) ? 3'd2 : 3'd1;
      default: n = 3'd1;
    endcase
    err = job_r.bad || (off_r >= REG_LIMIT);
    fin = job_r.empty || err || ({4'd0, n} >= left);
  end

  assign slot_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    off_r    <= off_nxt;
    done_r   <= done_nxt;
    addr_r   <= addr_nxt;
    busv_r   <= busv_nxt;
    port_r   <= port_nxt;
    nbytes_r <= nbytes_nxt;
    bdone_r  <= bdone_nxt;
    wr_r     <= wr_nxt;
    err_r    <= err_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    off_nxt    = off_r;
    done_nxt   = done_r;
    job_pop    = 1'b0;
    load       = 1'b0;
    valid_nxt  = valid_r && !out_tready;
    addr_nxt   = addr_r;
    busv_nxt   = busv_r;
    port_nxt   = port_r;
    nbytes_nxt = nbytes_r;
    bdone_nxt  = bdone_r;
    wr_nxt     = wr_r;
    err_nxt    = err_r;
    last_nxt   = last_r;
    case (state_r)
      ST_IDLE: begin
        job_pop = job_valid;
        if (job_valid) begin
          job_nxt   = job;
          off_nxt   = {1'b0, job.off};
          done_nxt  = 7'd0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        load = slot_free;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      valid_nxt  = 1'b1;
      wr_nxt     = job_r.wr;
      last_nxt   = fin;
      bdone_nxt  = done_r;
      addr_nxt   = 32'd0;
      busv_nxt   = 8'd0;
      port_nxt   = 16'd0;
      nbytes_nxt = 3'd0;
      err_nxt    = 1'b0;
      if (job_r.empty) begin
        bdone_nxt = 7'd0;
      end else if (err) begin
        err_nxt = 1'b1;
      end else begin
        nbytes_nxt = n;
        if (job_r.mech2) begin
          addr_nxt = {24'd0, ENABLE2 | {4'd0, job_r.func, 1'b0}};
          busv_nxt = job_r.bus;
          port_nxt = PORT_BASE2 | {4'd0, job_r.dev[3:0], off_r[7:0]};
        end else begin
          addr_nxt = CONF_ENABLE | {8'd0, job_r.bus, job_r.dev, job_r.func,
                                    off_r[7:2], 2'b00};
          port_nxt = PORT_ADDR1 | {14'd0, lo};
        end
      end
      off_nxt  = off_r + {6'd0, n};
      done_nxt = done_r + {4'd0, n};
      if (fin) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_addr   = addr_r;
  assign out_busv   = busv_r;
  assign out_port   = port_r;
  assign out_nbytes = nbytes_r;
  assign out_done   = bdone_r;
  assign out_wr     = wr_r;
  assign out_err    = err_r;
  assign out_last   = last_r;

endmodule

[sv/pcas_checker.sv]
// Port-level checks for the PCI configuration access splitter, bound to the top level.
// Depends on pci_config_access_splitter_unit ports only.
module pcas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // A rejected chunk ends the run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("error beat without last");

  // Chunk size is 0, 1, 2 or 4, and zero only on a final beat
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[58:56] == 3'd0 && out_tlast) || out_tdata[58:56] == 3'd1 ||
                   out_tdata[58:56] == 3'd2 || out_tdata[58:56] == 3'd4)
    else $error("bad chunk size");

  // A rejected chunk carries no access
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[58:0] == 59'd0)
    else $error("error beat carries access fields");

  // Reset drops any pending beat
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

endmodule

bind pci_config_access_splitter_unit pcas_checker u_pcas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
